FILE: hw/rtl/dtq_pkg.sv
package dtq_pkg;

    localparam int ID_BITS        = 4;
    localparam int ID_COUNT       = 2 ** ID_BITS;
    localparam int COUNT_BITS     = 5;
    localparam int ENTRIES_DEF    = 16;
    localparam int DELAY_BITS_DEF = 32;
    localparam int IN_DELAY_BITS  = 32;

    localparam logic [1:0] ACT_PEEK   = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_LINKED   = 2'd2;
    localparam logic [1:0] ST_UNLINKED = 2'd3;

    typedef struct packed {
        logic [1:0]               action;
        logic [ID_BITS-1:0]       entry_id;
        logic [IN_DELAY_BITS-1:0] delay;
    } t_dtq_in;

    typedef struct packed {
        logic [1:0]               status;
        logic                     head_valid;
        logic [ID_BITS-1:0]       head_id;
        logic [IN_DELAY_BITS-1:0] head_delta;
        logic [COUNT_BITS-1:0]    entry_count;
    } t_dtq_out;

    // Wave travelling down the chain of cells
    typedef enum logic [2:0] {
        LK_IDLE,
        LK_INS,
        LK_SHIFT,
        LK_REM,
        LK_PULL
    } t_dtq_mode;

    typedef struct packed {
        t_dtq_mode          mode;
        logic [ID_BITS-1:0] id;
    } t_dtq_ctl;

endpackage

FILE: hw/rtl/dtq_cell.sv
module dtq_cell import dtq_pkg::*; #(
    parameter int DELAY_BITS = DELAY_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dtq_ctl              i_ctl,
    input  logic [DELAY_BITS-1:0] i_link_delta,
    input  logic                  i_nxt_valid,
    input  logic [ID_BITS-1:0]    i_nxt_id,
    input  logic [DELAY_BITS-1:0] i_nxt_delta,
    output t_dtq_ctl              o_ctl,
    output logic [DELAY_BITS-1:0] o_link_delta,
    output logic                  o_valid,
    output logic [ID_BITS-1:0]    o_id,
    output logic [DELAY_BITS-1:0] o_delta
);

    logic                  r_valid, n_valid;
    logic [ID_BITS-1:0]    r_id, n_id;
    logic [DELAY_BITS-1:0] r_delta, n_delta;
    t_dtq_ctl              r_ctl, n_ctl;
    logic [DELAY_BITS-1:0] r_ld, n_ld;

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_delta = r_delta;
        n_ctl   = '{mode: LK_IDLE, id: r_id};
        n_ld    = r_delta;

        // close the gap left by a removal: take the right neighbour's entry
        if (r_ctl.mode == LK_PULL) begin
            n_valid = i_nxt_valid;
            n_id    = i_nxt_id;
            n_delta = i_nxt_delta + r_ld;
        end

        unique case (i_ctl.mode)
            LK_INS: begin
                if (!r_valid) begin
                    n_valid = 1'b1;
                    n_id    = i_ctl.id;
                    n_delta = i_link_delta;
                end else if (i_link_delta < r_delta) begin
                    n_id    = i_ctl.id;
                    n_delta = i_link_delta;
                    n_ctl   = '{mode: LK_SHIFT, id: r_id};
                    n_ld    = r_delta - i_link_delta;
                end else begin
                    n_ctl = '{mode: LK_INS, id: i_ctl.id};
                    n_ld  = i_link_delta - r_delta;
                end
            end
            LK_SHIFT: begin
                n_valid = 1'b1;
                n_id    = i_ctl.id;
                n_delta = i_link_delta;
                if (r_valid) begin
                    n_ctl = '{mode: LK_SHIFT, id: r_id};
                    n_ld  = r_delta;
                end
            end
            LK_REM: begin
                if (r_valid) begin
                    if (r_id == i_ctl.id) begin
                        n_ctl = '{mode: LK_PULL, id: r_id};
                        n_ld  = r_delta;
                    end else begin
                        n_ctl = '{mode: LK_REM, id: i_ctl.id};
                    end
                end
            end
            LK_PULL: begin
                // the left cell takes this entry now; pass the gap on
                if (r_valid) begin
                    n_ctl = '{mode: LK_PULL, id: r_id};
                    n_ld  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ctl   <= '{mode: LK_IDLE, id: '0};
        end else begin
            r_valid <= n_valid;
            r_ctl   <= n_ctl;
            r_id    <= n_id;
            r_delta <= n_delta;
            r_ld    <= n_ld;
        end
    end

    assign o_ctl        = r_ctl;
    assign o_link_delta = r_ld;
    assign o_valid      = r_valid;
    assign o_id         = r_id;
    assign o_delta      = r_delta;

endmodule

FILE: hw/rtl/delta_timer_queue_unit.sv
// Delta-list timer queue. A row of ENTRIES cells holds the linked timers in
// deadline order, each storing its delay relative to the one before it. An
// insert or remove runs as a wave that moves one cell per clock down the row;
// a peek, or an insert or remove rejected by the status checks, sends no
// wave. A result still held by a stall on the output delays the finish of the
// next item. One item is worked on at a time; a finished result sits in an
// output register and the next item may be accepted while it waits. Every
// result carries the head entry, its delta and the number of linked entries
// after the item.
module delta_timer_queue_unit import dtq_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int DELAY_BITS = DELAY_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dtq_in  i_in_item,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_dtq_out o_out_item
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state                r_state;
    t_dtq_ctl              r_link;
    logic [DELAY_BITS-1:0] r_link_delta;
    logic [ID_COUNT-1:0]   r_mask;
    logic [CNT_W-1:0]      r_count;
    logic [1:0]            r_status;
    logic                  r_out_valid;
    t_dtq_out              r_out_item;

    t_dtq_ctl              w_ctl       [ENTRIES];
    logic [DELAY_BITS-1:0] w_link_delta[ENTRIES];
    logic                  w_valid     [ENTRIES];
    logic [ID_BITS-1:0]    w_id        [ENTRIES];
    logic [DELAY_BITS-1:0] w_delta     [ENTRIES];
    logic [ENTRIES-1:0]    w_busy_vec;

    logic                  w_accept;
    logic                  w_linked;
    logic                  w_full;
    logic                  w_idle_chain;
    logic                  w_slot_free;
    logic [1:0]            w_status;
    t_dtq_mode             w_mode;

    genvar k;
    generate
        for (k = 0; k < ENTRIES; k++) begin : g_cell
            t_dtq_ctl              w_cin;
            logic [DELAY_BITS-1:0] w_din;
            logic                  w_nv;
            logic [ID_BITS-1:0]    w_ni;
            logic [DELAY_BITS-1:0] w_nd;

            if (k == 0) begin : g_first
                assign w_cin = r_link;
                assign w_din = r_link_delta;
            end else begin : g_mid
                assign w_cin = w_ctl[k-1];
                assign w_din = w_link_delta[k-1];
            end

            if (k == ENTRIES - 1) begin : g_last
                assign w_nv = 1'b0;
                assign w_ni = '0;
                assign w_nd = '0;
            end else begin : g_inner
                assign w_nv = w_valid[k+1];
                assign w_ni = w_id[k+1];
                assign w_nd = w_delta[k+1];
            end

            dtq_cell #(
                .DELAY_BITS(DELAY_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_cin),
                .i_link_delta(w_din),
                .i_nxt_valid (w_nv),
                .i_nxt_id    (w_ni),
                .i_nxt_delta (w_nd),
                .o_ctl       (w_ctl[k]),
                .o_link_delta(w_link_delta[k]),
                .o_valid     (w_valid[k]),
                .o_id        (w_id[k]),
                .o_delta     (w_delta[k])
            );

            assign w_busy_vec[k] = (w_ctl[k].mode != LK_IDLE);
        end
    endgenerate

    assign w_accept     = i_in_valid && (r_state == S_IDLE);
    assign w_linked     = r_mask[i_in_item.entry_id];
    assign w_full       = (r_count == CNT_W'(ENTRIES));
    assign w_idle_chain = (r_link.mode == LK_IDLE) && !(|w_busy_vec);
    assign w_slot_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        w_status = ST_OK;
        w_mode   = LK_IDLE;
        priority if (i_in_item.action == ACT_INSERT) begin
            if (w_linked) begin
                w_status = ST_LINKED;
            end else if (w_full) begin
                w_status = ST_FULL;
            end else begin
                w_mode = LK_INS;
            end
        end else if (i_in_item.action == ACT_REMOVE) begin
            if (!w_linked) begin
                w_status = ST_UNLINKED;
            end else begin
                w_mode = LK_REM;
            end
        end else begin
            w_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_link      <= '{mode: LK_IDLE, id: '0};
            r_mask      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_RUN) && w_idle_chain && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state      <= S_RUN;
                        r_status     <= w_status;
                        r_link       <= '{mode: w_mode, id: i_in_item.entry_id};
                        r_link_delta <= DELAY_BITS'(i_in_item.delay);
                        if (w_mode == LK_INS) begin
                            r_mask[i_in_item.entry_id] <= 1'b1;
                            r_count <= r_count + 1'b1;
                        end else if (w_mode == LK_REM) begin
                            r_mask[i_in_item.entry_id] <= 1'b0;
                            r_count <= r_count - 1'b1;
                        end
                    end
                end
                S_RUN: begin
                    // the controller feeds cell 0 for one cycle only
                    r_link <= '{mode: LK_IDLE, id: r_link.id};
                    if (w_idle_chain && w_slot_free) begin
                        r_state                 <= S_IDLE;
                        r_out_item.status       <= r_status;
                        r_out_item.head_valid   <= w_valid[0];
                        r_out_item.head_id      <= w_valid[0] ? w_id[0] : '0;
                        r_out_item.head_delta   <= w_valid[0] ?
                                                   IN_DELAY_BITS'(w_delta[0]) : '0;
                        r_out_item.entry_count  <= COUNT_BITS'(r_count);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: hw/rtl/dtq_checker.sv
module dtq_checker import dtq_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input t_dtq_in  i_in_item,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_dtq_out o_out_item
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // one item at a time: the input is stalled in the cycle after an item is accepted
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after acceptance");

    a_head_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.head_valid == (o_out_item.entry_count != '0)))
        else $error("head valid disagrees with entry count");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.head_valid |->
            (o_out_item.head_id == '0) && (o_out_item.head_delta == '0))
        else $error("empty list reports a head entry");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.entry_count <= COUNT_BITS'(ID_COUNT)))
        else $error("entry count beyond the number of ids");

endmodule

bind delta_timer_queue_unit dtq_checker u_dtq_checker (.*);

FILE: tb/timer_queue_checker.sv
`timescale 1ns / 100ps

module timer_queue_checker import dtq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_dtq_in  i_in_item,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_dtq_out i_out_item,
    output int       o_fail_count,
    output int       o_pending
);

    // Shadow copy of the delta list, slot 0 is the head
    logic [ID_BITS-1:0]       slot_id    [ENTRIES_DEF];
    logic [IN_DELAY_BITS-1:0] slot_delta [ENTRIES_DEF];
    logic [ID_COUNT-1:0]      linked;
    int                       linked_count;

    t_dtq_out awaited_heads [$];
    int       faults = 0;
    int       results_seen = 0;

    task automatic advance_timer_list(input t_dtq_in item, output t_dtq_out head);
        logic [IN_DELAY_BITS-1:0] rest;
        int pos;
        int k;
        bit placed;
        head        = '0;
        head.status = ST_OK;
        case (item.action)
            ACT_INSERT: begin
                if (linked[item.entry_id]) begin
                    head.status = ST_LINKED;
                end else if (linked_count >= ENTRIES_DEF) begin
                    head.status = ST_FULL;
                end else begin
                    rest   = item.delay;
                    pos    = 0;
                    placed = 1'b0;
                    // walk past every deadline not later than the new one
                    while (pos < linked_count && !placed) begin
                        if (rest < slot_delta[pos]) begin
                            slot_delta[pos] = slot_delta[pos] - rest;
                            placed = 1'b1;
                        end else begin
                            rest = rest - slot_delta[pos];
                            pos++;
                        end
                    end
                    for (k = linked_count; k > pos; k--) begin
                        slot_id[k]    = slot_id[k-1];
                        slot_delta[k] = slot_delta[k-1];
                    end
                    slot_id[pos]           = item.entry_id;
                    slot_delta[pos]        = rest;
                    linked_count           = linked_count + 1;
                    linked[item.entry_id]  = 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (!linked[item.entry_id]) begin
                    head.status = ST_UNLINKED;
                end else begin
                    pos = 0;
                    while (pos < linked_count && slot_id[pos] != item.entry_id)
                        pos++;
                    // hand the removed delta on to the successor, if any
                    if (pos + 1 < linked_count)
                        slot_delta[pos+1] = slot_delta[pos+1] + slot_delta[pos];
                    for (k = pos; k + 1 < linked_count; k++) begin
                        slot_id[k]    = slot_id[k+1];
                        slot_delta[k] = slot_delta[k+1];
                    end
                    linked_count          = linked_count - 1;
                    linked[item.entry_id] = 1'b0;
                end
            end
            default: ;
        endcase
        if (linked_count != 0) begin
            head.head_valid = 1'b1;
            head.head_id    = slot_id[0];
            head.head_delta = slot_delta[0];
        end
        head.entry_count = COUNT_BITS'(linked_count);
    endtask

    task automatic note_fault(input string what, input t_dtq_out want,
                              input t_dtq_out got);
        faults++;
        if (faults <= 10)
            $display({"%0t result %0d %s: want st=%0d hv=%0b id=%0d dl=%h n=%0d,",
                      " got st=%0d hv=%0b id=%0d dl=%h n=%0d"},
                     $time, results_seen, what,
                     want.status, want.head_valid, want.head_id, want.head_delta,
                     want.entry_count,
                     got.status, got.head_valid, got.head_id, got.head_delta,
                     got.entry_count);
    endtask

    always @(posedge i_clk) begin : watch
        t_dtq_out predicted;
        t_dtq_out awaited;
        t_dtq_out observed;
        if (!i_rst_n) begin
            linked       = '0;
            linked_count = 0;
            awaited_heads.delete();
            o_pending <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                advance_timer_list(i_in_item, predicted);
                awaited_heads.push_back(predicted);
            end
            if (i_out_valid && !i_out_stall) begin
                observed = i_out_item;
                results_seen++;
                if (awaited_heads.size() == 0) begin
                    note_fault("with nothing awaited", '0, observed);
                end else begin
                    awaited = awaited_heads.pop_front();
                    if (awaited.status !== observed.status ||
                        awaited.head_valid !== observed.head_valid ||
                        awaited.head_id !== observed.head_id ||
                        awaited.head_delta !== observed.head_delta ||
                        awaited.entry_count !== observed.entry_count)
                        note_fault("differs", awaited, observed);
                end
            end
            o_pending <= awaited_heads.size();
        end
        o_fail_count <= faults;
    end

endmodule

FILE: tb/delta_timer_queue_unit_test.sv
`timescale 1ns / 100ps

module delta_timer_queue_unit_test;
    import dtq_pkg::*;

    localparam logic [1:0] ACT_SPARE   = 2'd3;
    localparam int         ITEMS_EACH  = 130;
    localparam int         PHASES      = 5;
    localparam int         HOLD_LEN    = 300;
    localparam int         QUIET_LIMIT = 3000;
    localparam int         DRAIN_WAIT  = 40;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     out_stall = 1'b0;
    t_dtq_in  in_item   = '0;
    logic     in_stall;
    logic     out_valid;
    t_dtq_out out_item;

    int       fail_count;
    int       pending;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_phase     = 1'b0;
    int unsigned held           = 0;
    int unsigned quiet_cycles   = 0;

    // ids believed linked, used only to steer the stimulus
    logic [ID_COUNT-1:0] linked_ids = '0;

    delta_timer_queue_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    timer_queue_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: one long hold-off at the start of the pressure phase, else random stalls
    always @(posedge clk) begin
        if (hold_phase && held < HOLD_LEN) begin
            held      <= held + 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_timer_item(input logic [1:0] action, input logic [ID_BITS-1:0] id,
                                   input logic [IN_DELAY_BITS-1:0] delay);
        t_dtq_in item;
        item.action   = action;
        item.entry_id = id;
        item.delay    = delay;
        while ($urandom_range(99, 0) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (action == ACT_INSERT) linked_ids[id] = 1'b1;
        if (action == ACT_REMOVE) linked_ids[id] = 1'b0;
    endtask

    function automatic logic [ID_BITS-1:0] pick_id(input logic [ID_COUNT-1:0] pool);
        logic [ID_BITS-1:0] id;
        id = ID_BITS'($urandom_range(ID_COUNT - 1, 0));
        if (pool == '0) return id;
        while (!pool[id]) id = id + 1'b1;
        return id;
    endfunction

    function automatic logic [IN_DELAY_BITS-1:0] pick_delay();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 40) return $urandom_range(15, 0);
        if (r < 65) return $urandom_range(300, 0);
        if (r < 85) return $urandom();
        if (r < 95) return '0;
        return '1;
    endfunction

    initial begin : stimulus
        int phase;
        int n;
        int burst_left;
        bit filling;
        int unsigned r;
        logic [ID_BITS-1:0] id;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, then ties, extremes and removal from head, middle and tail
        send_timer_item(ACT_PEEK,   4'd2,  $urandom());
        send_timer_item(ACT_REMOVE, 4'd5,  $urandom());
        send_timer_item(ACT_INSERT, 4'd0,  32'd0);
        send_timer_item(ACT_INSERT, 4'd15, 32'hFFFF_FFFF);
        send_timer_item(ACT_INSERT, 4'd3,  32'd0);
        send_timer_item(ACT_INSERT, 4'd7,  32'd100);
        send_timer_item(ACT_INSERT, 4'd8,  32'd100);
        send_timer_item(ACT_INSERT, 4'd9,  32'd50);
        send_timer_item(ACT_INSERT, 4'd10, 32'h8000_0000);
        send_timer_item(ACT_INSERT, 4'd0,  32'd5);
        send_timer_item(ACT_SPARE,  4'd0,  $urandom());
        send_timer_item(ACT_REMOVE, 4'd0,  $urandom());
        send_timer_item(ACT_REMOVE, 4'd7,  $urandom());
        send_timer_item(ACT_REMOVE, 4'd15, $urandom());
        send_timer_item(ACT_REMOVE, 4'd15, $urandom());
        send_timer_item(ACT_PEEK,   4'd15, 32'hFFFF_FFFF);
        send_timer_item(ACT_REMOVE, 4'd3,  $urandom());
        send_timer_item(ACT_REMOVE, 4'd9,  $urandom());
        send_timer_item(ACT_REMOVE, 4'd10, $urandom());
        send_timer_item(ACT_REMOVE, 4'd8,  $urandom());
        send_timer_item(ACT_INSERT, 4'd12, 32'd1);

        burst_left = 0;
        filling    = 1'b1;
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 88; end
                3: begin send_idle_pct = 35; recv_stall_pct <= 35; end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                    hold_phase     <= 1'b1;
                end
            endcase
            for (n = 0; n < ITEMS_EACH; n++) begin
                // mix filling and draining bursts, chosen at random, so the list reaches both ends
                if (burst_left == 0) begin
                    filling    = 1'($urandom_range(1, 0));
                    burst_left = $urandom_range(30, 6);
                end
                burst_left--;
                r = $urandom_range(99, 0);
                if (r < 4) begin
                    send_timer_item(ACT_PEEK, ID_BITS'($urandom()), $urandom());
                end else if (r < 8) begin
                    send_timer_item(ACT_SPARE, ID_BITS'($urandom()), $urandom());
                end else if (filling ? r < 80 : r < 28) begin
                    id = ($urandom_range(99, 0) < 85) ?
                         pick_id(~linked_ids) : ID_BITS'($urandom_range(ID_COUNT - 1, 0));
                    send_timer_item(ACT_INSERT, id, pick_delay());
                end else begin
                    id = ($urandom_range(99, 0) < 85) ?
                         pick_id(linked_ids) : ID_BITS'($urandom_range(ID_COUNT - 1, 0));
                    send_timer_item(ACT_REMOVE, id, $urandom());
                end
            end
        end
        in_valid       <= 1'b0;
        recv_stall_pct <= 0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_cell.sv
hw/rtl/delta_timer_queue_unit.sv
hw/rtl/dtq_checker.sv
tb/timer_queue_checker.sv
tb/delta_timer_queue_unit_test.sv
